[sv/pci_pkg.sv]
// shared types, constants and helpers for the collision impulse core
package pci_pkg;

   localparam int unsigned MAX_PARTICLES_DEF = 65536;
   localparam int unsigned COORD_WIDTH_DEF   = 32;
   localparam int unsigned CSR_INDEX_WIDTH   = 2;
   localparam int unsigned DEPTH_WIDTH       = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIST_SQ     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESTITUTION = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_STEP   = 2'd2;

   localparam logic OP_LOAD      = 1'b0;
   localparam logic OP_NEIGHBOUR = 1'b1;

   localparam logic [1:0] TYPE_FLUID = 2'd0;
   localparam logic [1:0] TYPE_GHOST = 2'd2;

   typedef struct packed {
      logic              op;
      logic [15:0]       particle_index;
      logic [1:0]        particle_type;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic              is_last;
   } req_type;

   typedef struct packed {
      logic [15:0]       out_index;
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
   } rsp_type;

   // saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -hi - 64'sd1;
      if (x > hi) return 32'sh7FFF_FFFF;
      else if (x < lo) return 32'sh8000_0000;
      else return x[31:0];
   endfunction

endpackage

[sv/pci_queue.sv]
// small first-in first-out queue, used for the request queue and the result queue
module pci_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, rd_ff;
   logic [AW:0]      cnt_ff;

   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign dout  = mem_ff[rd_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wr_ff] <= din;
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push && !full)
            wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + AW'(1);
         if (pop && !empty)
            rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + AW'(1);
         cnt_ff <= cnt_ff + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
      end
   end
endmodule

[sv/pci_back.sv]
// back part: runs loads, neighbour impulses and result generation over cycles
module pci_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      dist_sq,
   input  logic [16:0]      restitution,
   input  logic [15:0]      time_step,
   input  pci_pkg::req_type cmd,
   input  logic             cmd_valid,
   output logic             cmd_take,
   output pci_pkg::rsp_type rsp,
   output logic             rsp_valid,
   input  logic             rsp_full
);
   import pci_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DIFF, S_SQ, S_SQRT, S_DIV, S_DOT, S_DOTSUM, S_G, S_UPD, S_OUT, S_EMIT
   } state_type;

   state_type          state_ff;
   req_type            cur_ff;
   logic [15:0]        cidx_ff;
   logic               cfluid_ff;
   logic signed [31:0] cpos_ff [3];
   logic signed [31:0] cvel_ff [3];
   logic signed [31:0] rvel_ff [3];
   logic signed [32:0] d_ff [3];
   logic [63:0]        d2_ff;
   // square root unit
   logic [63:0]        sq_rem_ff;
   logic [31:0]        sq_root_ff;
   logic [5:0]         cnt_ff;
   // divider
   logic [49:0]        dv_num_ff;
   logic [49:0]        dv_rem_ff;
   logic [1:0]         lane_ff;
   logic signed [17:0] n_ff [3];
   logic signed [51:0] prod_ff [3];
   logic signed [39:0] f_ff;
   logic signed [39:0] g_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic signed [32:0] nb_pos [3];
   logic signed [32:0] nb_vel [3];
   logic               out_range;
   logic [50:0]        dv_trial;
   logic signed [31:0] src_pos [3];
   logic signed [31:0] src_vel [3];
   logic signed [24:0] ds [3];
   logic signed [18:0] e_scale;
   logic signed [49:0] dt_prod [3];

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;
   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid;

   always_comb begin
      nb_pos[0] = 33'(cur_ff.pos_x); nb_pos[1] = 33'(cur_ff.pos_y);
      nb_pos[2] = 33'(cur_ff.pos_z);
      nb_vel[0] = 33'(cur_ff.vel_x); nb_vel[1] = 33'(cur_ff.vel_y);
      nb_vel[2] = 33'(cur_ff.vel_z);
      src_pos[0] = cmd.pos_x; src_pos[1] = cmd.pos_y; src_pos[2] = cmd.pos_z;
      src_vel[0] = cmd.vel_x; src_vel[1] = cmd.vel_y; src_vel[2] = cmd.vel_z;
      out_range = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (d_ff[k] >= 33'sd16777216 || d_ff[k] <= -33'sd16777216) out_range = 1'b1;
         // in-range differences fit 25 bits
         ds[k] = d_ff[k][24:0];
         // velocity change scaled by the time step
         dt_prod[k] = 50'((33'(rvel_ff[k]) - 33'(cvel_ff[k]))
                          * $signed({1'b0, time_step}));
      end
      e_scale  = $signed(19'd65536 + 19'(restitution));
      dv_trial = {dv_rem_ff, dv_num_ff[49]} - {19'b0, sq_root_ff};
   end

   // control and datapath sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cidx_ff      <= '0;
         cfluid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            cpos_ff[k] <= '0;
            cvel_ff[k] <= '0;
            rvel_ff[k] <= '0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_full) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cur_ff <= cmd;
                  if (cmd.op == OP_LOAD) begin
                     cidx_ff   <= cmd.particle_index;
                     cfluid_ff <= (cmd.particle_type == TYPE_FLUID);
                     for (int k = 0; k < 3; k++) begin
                        cpos_ff[k] <= src_pos[k];
                        cvel_ff[k] <= src_vel[k];
                        rvel_ff[k] <= src_vel[k];
                     end
                     state_ff <= cmd.is_last ? S_OUT : S_IDLE;
                  end else if (!cfluid_ff || cmd.particle_index == cidx_ff ||
                               cmd.particle_type == TYPE_GHOST) begin
                     state_ff <= cmd.is_last ? S_OUT : S_IDLE;
                  end else begin
                     state_ff <= S_DIFF;
                  end
               end
            end
            S_DIFF: begin
               for (int k = 0; k < 3; k++) d_ff[k] <= nb_pos[k] - 33'(cpos_ff[k]);
               state_ff <= S_SQ;
            end
            S_SQ: begin
               if (out_range) begin
                  state_ff <= cur_ff.is_last ? S_OUT : S_IDLE;
               end else begin
                  d2_ff <= 64'(50'(ds[0] * ds[0])) + 64'(50'(ds[1] * ds[1]))
                           + 64'(50'(ds[2] * ds[2]));
                  sq_root_ff <= '0;
                  cnt_ff     <= '0;
                  state_ff   <= S_SQRT;
               end
            end
            S_SQRT: begin
               // restoring square root, one result bit per cycle
               if (cnt_ff == 6'd0) begin
                  if (d2_ff == 64'd0 || d2_ff >= {dist_sq, 16'b0}) begin
                     state_ff <= cur_ff.is_last ? S_OUT : S_IDLE;
                  end else begin
                     sq_rem_ff <= d2_ff;
                     cnt_ff    <= 6'd1;
                  end
               end else begin
                  if (sq_rem_ff >= ({sq_root_ff, 32'b0} >> (7'(cnt_ff) - 7'd1)
                                    | (64'd1 << (7'd64 - 7'(cnt_ff) * 7'd2)))) begin
                     sq_rem_ff  <= sq_rem_ff - (({sq_root_ff, 32'b0} >> (7'(cnt_ff) - 7'd1))
                                    | (64'd1 << (7'd64 - 7'(cnt_ff) * 7'd2)));
                     sq_root_ff <= sq_root_ff | (32'd1 << (6'd32 - cnt_ff));
                  end
                  if (cnt_ff == 6'd32) begin
                     lane_ff  <= 2'd0;
                     cnt_ff   <= '0;
                     state_ff <= S_DIV;
                  end else begin
                     cnt_ff <= cnt_ff + 6'd1;
                  end
               end
            end
            S_DIV: begin
               // restoring division of |d|*2^16 by dist, one bit per cycle
               if (cnt_ff == 6'd0) begin
                  dv_num_ff <= {1'b0, (d_ff[lane_ff] < 0) ? 33'(-d_ff[lane_ff])
                                                          : d_ff[lane_ff], 16'b0};
                  dv_rem_ff <= '0;
                  cnt_ff    <= 6'd1;
               end else begin
                  if (!dv_trial[50]) begin
                     dv_rem_ff <= dv_trial[49:0];
                     dv_num_ff <= {dv_num_ff[48:0], 1'b1};
                  end else begin
                     dv_rem_ff <= {dv_rem_ff[48:0], dv_num_ff[49]};
                     dv_num_ff <= {dv_num_ff[48:0], 1'b0};
                  end
                  if (cnt_ff == 6'd50) begin
                     cnt_ff <= 6'd51;
                  end else if (cnt_ff == 6'd51) begin
                     // unit normal components never exceed 1.0
                     n_ff[lane_ff] <= (d_ff[lane_ff] < 0) ? -$signed(dv_num_ff[17:0])
                                                          : $signed(dv_num_ff[17:0]);
                     cnt_ff <= '0;
                     if (lane_ff == 2'd2) state_ff <= S_DOT;
                     else lane_ff <= lane_ff + 2'd1;
                  end else begin
                     cnt_ff <= cnt_ff + 6'd1;
                  end
               end
            end
            S_DOT: begin
               for (int k = 0; k < 3; k++)
                  prod_ff[k] <= (34'(rvel_ff[k]) - 34'(nb_vel[k])) * n_ff[k];
               state_ff <= S_DOTSUM;
            end
            S_DOTSUM: begin
               f_ff <= 40'((prod_ff[0] + prod_ff[1] + prod_ff[2]) >>> 16);
               state_ff <= S_G;
            end
            S_G: begin
               if (f_ff <= 0) begin
                  state_ff <= cur_ff.is_last ? S_OUT : S_IDLE;
               end else begin
                  g_ff <= 40'((60'(f_ff) * 60'(e_scale)) >>> 17);
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               for (int k = 0; k < 3; k++)
                  rvel_ff[k] <= sat32(64'(rvel_ff[k])
                                 - 64'(58'(g_ff * n_ff[k]) >>> 16));
               state_ff <= cur_ff.is_last ? S_OUT : S_IDLE;
            end
            S_OUT: begin
               // wait until the previous result has left the output register
               if (!rsp_valid_ff) begin
                  rsp_ff.out_index <= cidx_ff;
                  if (cfluid_ff) begin
                     rsp_ff.new_vel_x <= rvel_ff[0];
                     rsp_ff.new_vel_y <= rvel_ff[1];
                     rsp_ff.new_vel_z <= rvel_ff[2];
                     rsp_ff.new_pos_x <= sat32(64'(cpos_ff[0]) + 64'(dt_prod[0] >>> 16));
                     rsp_ff.new_pos_y <= sat32(64'(cpos_ff[1]) + 64'(dt_prod[1] >>> 16));
                     rsp_ff.new_pos_z <= sat32(64'(cpos_ff[2]) + 64'(dt_prod[2] >>> 16));
                  end else begin
                     rsp_ff.new_vel_x <= cvel_ff[0];
                     rsp_ff.new_vel_y <= cvel_ff[1];
                     rsp_ff.new_vel_z <= cvel_ff[2];
                     rsp_ff.new_pos_x <= cpos_ff[0];
                     rsp_ff.new_pos_y <= cpos_ff[1];
                     rsp_ff.new_pos_z <= cpos_ff[2];
                  end
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[sv/particle_collision_impulse_core.sv]
// top level of the particle collision impulse core
// flow: a load with is_last goes straight to result output; a neighbour in range passes
// the difference, squaring, square root, three normal divisions, dot product, impulse and
// update steps in the back part; skipped neighbours leave at the first failing check, or
// after the dot product when not closing; results pass a 2-entry output queue
// synchronous active-high reset clears control state, configuration registers and the centre state to zero
// throughput: one request at a time in the back part, a 4-entry request queue ahead
module particle_collision_impulse_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  pci_pkg::req_type                     req_data,
   output logic                                 empty,
   input  logic                                 pop,
   output pci_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pci_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [31:0]                          csr_data
);
   import pci_pkg::*;

   localparam int unsigned REQ_DEPTH = 4;

   logic [31:0] dist_sq_ff;
   logic [16:0] rest_ff;
   logic [15:0] dt_ff;
   req_type     q_dout;
   logic        q_empty, q_take;
   rsp_type     b_rsp;
   logic        b_valid, o_full;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_sq_ff <= '0;
         rest_ff    <= '0;
         dt_ff      <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DIST_SQ:     dist_sq_ff <= csr_data;
            CSR_RESTITUTION: rest_ff    <= csr_data[16:0];
            CSR_TIME_STEP:   dt_ff      <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // front: request queue
   pci_queue #(.WIDTH($bits(req_type)), .DEPTH(REQ_DEPTH)) u_req_q (
      .clock(clock), .reset(reset),
      .push(push), .din(req_data), .full(full),
      .pop(q_take), .dout(q_dout), .empty(q_empty)
   );

   pci_back u_back (
      .clock(clock), .reset(reset),
      .dist_sq(dist_sq_ff), .restitution(rest_ff), .time_step(dt_ff),
      .cmd(q_dout), .cmd_valid(!q_empty), .cmd_take(q_take),
      .rsp(b_rsp), .rsp_valid(b_valid), .rsp_full(o_full)
   );

   // result queue
   pci_queue #(.WIDTH($bits(rsp_type)), .DEPTH(2)) u_rsp_q (
      .clock(clock), .reset(reset),
      .push(b_valid), .din(b_rsp), .full(o_full),
      .pop(pop), .dout(rsp_data), .empty(empty)
   );
endmodule
